// File: rtl/pcb_pkg.sv
package pcb_pkg;

    localparam int NCHAN        = 8;
    localparam int SAMPLE_W     = 24;
    localparam int SEC_W        = 32;
    localparam int USEC_W       = 20;
    localparam int INDEX_W      = 10;
    localparam int COUNT_W      = 10;
    localparam int LEN_W        = 11;
    localparam int CHSEL_W      = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_INDEX_W  = 2;
    localparam int OP_W         = 2;
    localparam int DEPTH_DEFAULT = 1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(512);

    // One stored scan: eight channel codes, then seconds, then microseconds.
    localparam int ENTRY_W    = NCHAN * SAMPLE_W + SEC_W + USEC_W;
    localparam int IN_DATA_W  = ((ENTRY_W + INDEX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_STORE = 2'd0,
        OP_READ  = 2'd1,
        OP_REARM = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TRIGGER_CHANNEL = 2'd0,
        CFG_TRIGGER_LEVEL   = 2'd1,
        CFG_PRE_COUNT       = 2'd2,
        CFG_POST_COUNT      = 2'd3
    } cfg_index_t;

endpackage

// File: rtl/pcb_ram.sv
module pcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/pretrigger_capture_buffer_core.sv
// Pre/post-trigger capture buffer for eight-channel scans. Every input word
// gives exactly one output word, in order. A store word writes one scan into
// a ring of DEPTH entries held in a single-port synchronous RAM; a read word
// returns entry read_index of the frozen window, oldest first, with all data
// zero and out_valid low when the capture is not frozen or the index is past
// the window; a rearm word starts a new capture. The block takes one word per
// clock while there is room: each word makes one access to the RAM port, and
// its result goes, after the RAM read, into a four-word output queue so that
// input keeps flowing while the consumer stalls, until it fills. The RAM needs
// no clearing after reset, since reads never reach an unwritten entry.
module pretrigger_capture_buffer_core
    import pcb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata, from bit 0 up: ch0..ch7, stamp_sec, stamp_usec, read_index, zero fill
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // s_tuser: operation
    input  logic [OP_W-1:0]        s_tuser,
    // output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata, from bit 0 up: out_ch0..out_ch7, out_sec, out_usec, zero fill
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // m_tuser, from bit 0 up: capture_done, out_valid
    output logic [OUT_USER_W-1:0]  m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = (FW > LEN_W) ? FW : LEN_W;
    localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 2;
    localparam int QW = ENTRY_W + OUT_USER_W;

    // configuration registers
    logic [CHSEL_W-1:0]         trig_channel_reg;
    logic signed [SAMPLE_W-1:0] trig_level_reg;
    logic [COUNT_W-1:0]         pre_count_reg;
    logic [COUNT_W-1:0]         post_count_reg;

    // capture state
    logic [AW-1:0]      wp_reg, wp_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic               triggered_reg, triggered_next;
    logic [COUNT_W-1:0] post_cnt_reg, post_cnt_next;
    logic               frozen_reg, frozen_next;

    // read stage and output queue
    logic                 p1_valid_reg;
    logic                 p1_done_reg;
    logic                 p1_hit_reg;
    logic [QW-1:0]        queue_reg [4];
    logic [1:0]           q_wr_reg;
    logic [1:0]           q_rd_reg;
    logic [2:0]           q_count_reg, q_count_next;

    logic                 accept;
    op_t                  op;
    logic [INDEX_W-1:0]   read_k;
    logic signed [SAMPLE_W-1:0] trig_sample;
    logic                 trig_hit;
    logic [COUNT_W-1:0]   pre_eff;
    logic [COUNT_W-1:0]   post_eff;
    logic [LEN_W-1:0]     prepost;
    logic [CW-1:0]        len_wide;
    logic [LEN_W-1:0]     len;
    logic [SW-1:0]        addr_sum;
    logic [SW-1:0]        addr_wrap;
    logic [AW-1:0]        read_addr;
    logic                 read_hit;
    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [QW-1:0]        push_word;
    logic                 pop;

    assign accept = s_tvalid && s_tready;
    assign op     = op_t'(s_tuser);
    assign read_k = s_tdata[ENTRY_W +: INDEX_W];

    // Room is counted for the word in the read stage as well as the queue.
    assign s_tready = ({2'b00, p1_valid_reg} + q_count_reg) < 3'd4;

    // Window length: clamped pre plus post, limited by the stored history.
    assign pre_eff  = (pre_count_reg > COUNT_MAX) ? COUNT_MAX : pre_count_reg;
    assign post_eff = (post_count_reg == '0) ? COUNT_W'(1) :
                      ((post_count_reg > COUNT_MAX) ? COUNT_MAX : post_count_reg);
    assign prepost  = {1'b0, pre_eff} + {1'b0, post_eff};
    assign len_wide = (CW'(fill_reg) < CW'(prepost)) ? CW'(fill_reg) : CW'(prepost);
    assign len      = len_wide[LEN_W-1:0];

    // Entry wp - len + k, brought back into the ring when it goes negative.
    assign addr_sum  = SW'(wp_reg) + SW'(read_k) - SW'(len);
    assign addr_wrap = addr_sum[SW-1] ? (addr_sum + SW'(DEPTH)) : addr_sum;
    assign read_addr = addr_wrap[AW-1:0];
    assign read_hit  = frozen_reg && ({1'b0, read_k} < len);

    assign trig_sample = s_tdata[trig_channel_reg * SAMPLE_W +: SAMPLE_W];
    assign trig_hit    = trig_sample >= trig_level_reg;

    assign ram_we   = accept && (op == OP_STORE) && !frozen_reg;
    assign ram_addr = (op == OP_STORE) ? wp_reg : read_addr;

    always_comb
    begin
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        triggered_next = triggered_reg;
        post_cnt_next  = post_cnt_reg;
        frozen_next    = frozen_reg;
        if (accept)
        begin
            case (op)
                OP_STORE:
                begin
                    if (!frozen_reg)
                    begin
                        wp_next = ({1'b0, wp_reg} == (AW + 1)'(DEPTH - 1)) ? '0 :
                                  wp_reg + AW'(1);
                        if (fill_reg < FW'(DEPTH))
                        begin
                            fill_next = fill_reg + FW'(1);
                        end
                        triggered_next = triggered_reg || trig_hit;
                        if (triggered_next)
                        begin
                            if (post_cnt_reg < COUNT_MAX)
                            begin
                                post_cnt_next = post_cnt_reg + COUNT_W'(1);
                            end
                            if (post_cnt_next >= post_eff)
                            begin
                                frozen_next = 1'b1;
                            end
                        end
                    end
                end
                OP_REARM:
                begin
                    wp_next        = '0;
                    fill_next      = '0;
                    triggered_next = 1'b0;
                    post_cnt_next  = '0;
                    frozen_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    pcb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_tdata[ENTRY_W-1:0]),
        .rdata (ram_rdata)
    );

    assign push_word = {p1_hit_reg, p1_done_reg, p1_hit_reg ? ram_rdata : {ENTRY_W{1'b0}}};
    assign pop       = m_tvalid && m_tready;

    always_comb
    begin
        q_count_next = q_count_reg;
        if (p1_valid_reg && !pop)
        begin
            q_count_next = q_count_reg + 3'd1;
        end
        else if (!p1_valid_reg && pop)
        begin
            q_count_next = q_count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_channel_reg <= '0;
            trig_level_reg   <= '0;
            pre_count_reg    <= '0;
            post_count_reg   <= COUNT_W'(1);
            wp_reg           <= '0;
            fill_reg         <= '0;
            triggered_reg    <= 1'b0;
            post_cnt_reg     <= '0;
            frozen_reg       <= 1'b0;
            p1_valid_reg     <= 1'b0;
            p1_done_reg      <= 1'b0;
            p1_hit_reg       <= 1'b0;
            q_wr_reg         <= '0;
            q_rd_reg         <= '0;
            q_count_reg      <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TRIGGER_CHANNEL: trig_channel_reg <= cfg_data[CHSEL_W-1:0];
                    CFG_TRIGGER_LEVEL:   trig_level_reg   <= cfg_data[SAMPLE_W-1:0];
                    CFG_PRE_COUNT:       pre_count_reg    <= cfg_data[COUNT_W-1:0];
                    CFG_POST_COUNT:      post_count_reg   <= cfg_data[COUNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            triggered_reg <= triggered_next;
            post_cnt_reg  <= post_cnt_next;
            frozen_reg    <= frozen_next;
            p1_valid_reg  <= accept;
            p1_done_reg   <= frozen_next;
            p1_hit_reg    <= accept && (op == OP_READ) && read_hit;
            if (p1_valid_reg)
            begin
                q_wr_reg <= q_wr_reg + 2'd1;
            end
            if (pop)
            begin
                q_rd_reg <= q_rd_reg + 2'd1;
            end
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            queue_reg[q_wr_reg] <= push_word;
        end
    end

    assign m_tvalid = q_count_reg != 3'd0;
    assign m_tdata  = {{(OUT_DATA_W - ENTRY_W){1'b0}}, queue_reg[q_rd_reg][ENTRY_W-1:0]};
    assign m_tuser  = queue_reg[q_rd_reg][ENTRY_W +: OUT_USER_W];

endmodule

// File: rtl/pcb_checker.sv
module pcb_checker
    import pcb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [OUT_USER_W-1:0] m_tuser
);

    // A valid window entry is only ever returned from a frozen capture.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("window entry returned without a frozen capture");

    // Data fields are zero whenever the word carries no window entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata == '0)
        else $error("nonzero data on a word without a valid entry");

    // A word accepted while the output is empty reaches the output after the read stage and the queue write.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid)
        else $error("accepted word did not reach the output");

    // With nothing waiting at the output there is always room for input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

    // A stalled output word holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

endmodule

bind pretrigger_capture_buffer_core pcb_checker u_pcb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pcb_pkg::*;

    localparam int RING        = DEPTH_DEFAULT;
    localparam int SMALL_ITEMS = 850;

    localparam logic [SAMPLE_W-1:0] CODE_MIN = 24'h800000;
    localparam logic [SAMPLE_W-1:0] CODE_MAX = 24'h7FFFFF;
    localparam int                  USEC_MAX = 999999;

    typedef logic [NCHAN-1:0][SAMPLE_W-1:0] scan_codes_t;

    typedef struct packed {
        logic                done;
        logic                valid;
        scan_codes_t         codes;
        logic [SEC_W-1:0]    sec;
        logic [USEC_W-1:0]   usec;
    } reply_t;

    // Tracks the capture state and the reply owed for every accepted word.
    class capture_ledger;
        logic [CHSEL_W-1:0]         trig_chan;
        logic signed [SAMPLE_W-1:0] trig_level;
        logic [COUNT_W-1:0]         pre_reg;
        logic [COUNT_W-1:0]         post_reg;

        scan_codes_t        scans [RING];
        logic [SEC_W-1:0]   secs  [RING];
        logic [USEC_W-1:0]  usecs [RING];

        int unsigned wr_ptr;
        int unsigned fill;
        int unsigned post_seen;
        bit          armed;
        bit          frozen;

        reply_t due_replies [$];
        int     errors;

        function new();
            trig_chan  = '0;
            trig_level = '0;
            pre_reg    = '0;
            post_reg   = COUNT_W'(1);
            wr_ptr     = 0;
            fill       = 0;
            post_seen  = 0;
            armed      = 1'b0;
            frozen     = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TRIGGER_CHANNEL: trig_chan  = val[CHSEL_W-1:0];
                CFG_TRIGGER_LEVEL:   trig_level = val[SAMPLE_W-1:0];
                CFG_PRE_COUNT:       pre_reg    = val[COUNT_W-1:0];
                CFG_POST_COUNT:      post_reg   = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned post_limit();
            int unsigned p;
            p = post_reg;
            if (p == 0) p = 1;
            if (p > COUNT_MAX) p = COUNT_MAX;
            return p;
        endfunction

        function int unsigned window_length();
            int unsigned pre;
            int unsigned len;
            pre = (pre_reg > COUNT_MAX) ? COUNT_MAX : pre_reg;
            len = pre + post_limit();
            if (len > fill) len = fill;
            return len;
        endfunction

        function int pending();
            return due_replies.size();
        endfunction

        function void note_word(op_t op, logic [IN_DATA_W-1:0] d);
            reply_t      r;
            scan_codes_t codes;
            int unsigned k;
            int unsigned len;
            int unsigned e;
            r = '0;
            codes = d[0 +: NCHAN*SAMPLE_W];
            case (op)
                OP_STORE:
                begin
                    if (!frozen)
                    begin
                        scans[wr_ptr] = codes;
                        secs[wr_ptr]  = d[NCHAN*SAMPLE_W +: SEC_W];
                        usecs[wr_ptr] = d[NCHAN*SAMPLE_W+SEC_W +: USEC_W];
                        if ($signed(codes[trig_chan]) >= trig_level) armed = 1'b1;
                        wr_ptr = (wr_ptr + 1) % RING;
                        if (fill < RING) fill++;
                        if (armed)
                        begin
                            if (post_seen < COUNT_MAX) post_seen++;
                            if (post_seen >= post_limit()) frozen = 1'b1;
                        end
                    end
                end
                OP_READ:
                begin
                    k   = d[ENTRY_W +: INDEX_W];
                    len = window_length();
                    if (frozen && k < len)
                    begin
                        e = (wr_ptr + RING - len + k) % RING;
                        r.valid = 1'b1;
                        r.codes = scans[e];
                        r.sec   = secs[e];
                        r.usec  = usecs[e];
                    end
                end
                OP_REARM:
                begin
                    wr_ptr    = 0;
                    fill      = 0;
                    armed     = 1'b0;
                    post_seen = 0;
                    frozen    = 1'b0;
                end
                default: ;
            endcase
            r.done = frozen;
            due_replies.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_word(logic [OUT_USER_W-1:0] user, logic [OUT_DATA_W-1:0] data);
            reply_t want;
            if (due_replies.size() == 0)
            begin
                report_mismatch($sformatf("output word with nothing due, user %h", user));
                return;
            end
            want = due_replies.pop_front();
            if (user[0] !== want.done)
                report_mismatch($sformatf("capture_done %b, want %b", user[0], want.done));
            if (user[1] !== want.valid)
                report_mismatch($sformatf("out_valid %b, want %b", user[1], want.valid));
            for (int i = 0; i < NCHAN; i++)
            begin
                if (data[i*SAMPLE_W +: SAMPLE_W] !== want.codes[i])
                    report_mismatch($sformatf("out_ch%0d %h, want %h", i,
                        data[i*SAMPLE_W +: SAMPLE_W], want.codes[i]));
            end
            if (data[NCHAN*SAMPLE_W +: SEC_W] !== want.sec)
                report_mismatch($sformatf("out_sec %h, want %h",
                    data[NCHAN*SAMPLE_W +: SEC_W], want.sec));
            if (data[NCHAN*SAMPLE_W+SEC_W +: USEC_W] !== want.usec)
                report_mismatch($sformatf("out_usec %h, want %h",
                    data[NCHAN*SAMPLE_W+SEC_W +: USEC_W], want.usec));
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wen   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]        s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;

    capture_ledger sb;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent    = 0;
    int hold_len      = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    pretrigger_capture_buffer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 clk = ~clk;

    // Output side: check every accepted word, then choose the next ready.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_word(m_tuser, m_tdata);
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [IN_DATA_W-1:0] pack_scan(scan_codes_t codes,
        logic [SEC_W-1:0] sec, logic [USEC_W-1:0] usec, logic [INDEX_W-1:0] idx);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[0 +: NCHAN*SAMPLE_W]              = codes;
        d[NCHAN*SAMPLE_W +: SEC_W]          = sec;
        d[NCHAN*SAMPLE_W+SEC_W +: USEC_W]   = usec;
        d[ENTRY_W +: INDEX_W]               = idx;
        return d;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_code();
        case ($urandom_range(0, 9))
            0: return CODE_MIN;
            1: return CODE_MAX;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic scan_codes_t rand_chans();
        scan_codes_t codes;
        for (int i = 0; i < NCHAN; i++)
            codes[i] = rand_code();
        return codes;
    endfunction

    function automatic logic [SEC_W-1:0] rand_sec();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return SEC_W'($urandom);
        endcase
    endfunction

    function automatic logic [USEC_W-1:0] rand_usec();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return USEC_W'(USEC_MAX);
            default: return USEC_W'($urandom_range(0, USEC_MAX));
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        return INDEX_W'($urandom);
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_word();
        return pack_scan(rand_chans(), rand_sec(), rand_usec(), rand_index());
    endfunction

    // Alternating full-scale codes; flip swaps which channels sit at the top.
    function automatic scan_codes_t edge_codes(bit flip);
        scan_codes_t codes;
        for (int i = 0; i < NCHAN; i++)
            codes[i] = ((i % 2 == 1) ^ flip) ? CODE_MAX : CODE_MIN;
        return codes;
    endfunction

    // Code for the selected channel: at or above the level when hot, below it
    // otherwise. Nothing lies below the lowest level, so that case is hot.
    function automatic logic [SAMPLE_W-1:0] trigger_code(bit hot);
        int lvl;
        int v;
        lvl = sb.trig_level;
        if (hot || lvl == -8388608)
        begin
            if ($urandom_range(0, 3) == 0) v = lvl;
            else v = lvl + int'($urandom_range(0, 8388607 - lvl));
        end
        else
        begin
            if ($urandom_range(0, 3) == 0) v = lvl - 1;
            else v = -8388608 + int'($urandom_range(0, lvl + 8388607));
        end
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic send_word(op_t op, logic [IN_DATA_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        sb.note_word(op, data);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic put_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Unused upper bits of the narrow registers carry random junk.
    task automatic set_capture_config(logic [CHSEL_W-1:0] chan, logic [SAMPLE_W-1:0] level,
        logic [COUNT_W-1:0] pre, logic [COUNT_W-1:0] post);
        logic [CFG_DATA_W-CHSEL_W-1:0] junk_chan;
        logic [CFG_DATA_W-COUNT_W-1:0] junk_pre;
        logic [CFG_DATA_W-COUNT_W-1:0] junk_post;
        junk_chan = $urandom;
        junk_pre  = $urandom;
        junk_post = $urandom;
        cfg_wen <= 1'b1;
        put_reg(CFG_TRIGGER_CHANNEL, {junk_chan, chan});
        put_reg(CFG_TRIGGER_LEVEL, level);
        put_reg(CFG_PRE_COUNT, {junk_pre, pre});
        put_reg(CFG_POST_COUNT, {junk_post, post});
        cfg_wen <= 1'b0;
    endtask

    task automatic send_store(bit hot);
        scan_codes_t codes;
        codes = rand_chans();
        codes[sb.trig_chan] = trigger_code(hot);
        send_word(OP_STORE, pack_scan(codes, rand_sec(), rand_usec(), rand_index()));
    endtask

    task automatic send_read(logic [INDEX_W-1:0] idx);
        send_word(OP_READ, pack_scan(rand_chans(), rand_sec(), rand_usec(), idx));
    endtask

    task automatic send_fixed_store(scan_codes_t codes, logic [SEC_W-1:0] sec,
        logic [USEC_W-1:0] usec);
        send_word(OP_STORE, pack_scan(codes, sec, usec, rand_index()));
    endtask

    // Stray words dropped into a capture: no-ops, early reads, a rearm now and then.
    task automatic maybe_noise(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            case ($urandom_range(0, 4))
                0, 1: send_word(OP_NONE, rand_word());
                2, 3: send_word(OP_READ, rand_word());
                default: send_word(OP_REARM, rand_word());
            endcase
        end
    endtask

    // One full capture: rearm, quiet history, trigger, post samples until the
    // freeze, a few stores that must be dropped, then reads across the window.
    task automatic capture_run(int quiet, int reads, int noise_pct);
        int unsigned        len;
        logic [INDEX_W-1:0] idx;
        send_word(OP_REARM, rand_word());
        repeat (quiet)
        begin
            maybe_noise(noise_pct);
            send_store(1'b0);
        end
        send_store(1'b1);
        while (!sb.frozen)
        begin
            maybe_noise(noise_pct);
            send_store(1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(0, 2)) send_store(1'($urandom_range(0, 1)));
        len = sb.window_length();
        repeat (reads)
        begin
            case ($urandom_range(0, 9))
                0: idx = INDEX_W'(len);
                1: idx = rand_index();
                2: idx = '0;
                3: idx = (len > 0) ? INDEX_W'(len - 1) : rand_index();
                default: idx = (len > 0) ? INDEX_W'($urandom_range(0, len - 1)) : rand_index();
            endcase
            maybe_noise(noise_pct);
            send_read(idx);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return CODE_MIN;
            1: return CODE_MAX;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        scan_codes_t codes;
        int          start;
        int          progress;
        int          pre;
        int          post;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words with the registers at their reset values.
        send_idle_pct = 18;
        recv_idle_pct = 48;
        send_read('0);
        send_word(OP_NONE, rand_word());
        send_fixed_store(edge_codes(1'b0), '0, '0);
        send_fixed_store(edge_codes(1'b1), '1, USEC_W'(USEC_MAX));
        send_fixed_store(edge_codes(1'b0), SEC_W'(1), USEC_W'(1));
        send_read('0);
        send_read(INDEX_W'(1));
        send_read('1);
        send_word(OP_REARM, rand_word());
        send_read('0);

        // Lowest level fires on any code; post count of zero acts as one.
        wait_drained();
        set_capture_config(3'd7, CODE_MIN, 10'd2, 10'd0);
        send_word(OP_REARM, rand_word());
        send_fixed_store(edge_codes(1'b0), SEC_W'($urandom), rand_usec());
        send_fixed_store(edge_codes(1'b1), SEC_W'($urandom), rand_usec());
        send_read('0);
        send_read(INDEX_W'(1));

        // Highest level fires only on the top code.
        wait_drained();
        set_capture_config(3'd7, CODE_MAX, 10'd2, 10'd0);
        send_word(OP_REARM, rand_word());
        send_fixed_store(edge_codes(1'b1), SEC_W'($urandom), rand_usec());
        codes = edge_codes(1'b0);
        codes[7] = CODE_MAX - SAMPLE_W'(1);
        send_fixed_store(codes, SEC_W'($urandom), rand_usec());
        send_fixed_store(edge_codes(1'b0), SEC_W'($urandom), rand_usec());
        send_read('0);
        send_read(INDEX_W'(1));
        send_read(INDEX_W'(2));
        send_read(INDEX_W'(3));

        // Largest window with a wrapped ring; the output side holds off early
        // on so that the block backs up into its input.
        wait_drained();
        set_capture_config(3'($urandom), SAMPLE_W'($urandom), '1, '1);
        hold_len = 300;
        hold_seq++;
        capture_run(700, 20, 0);

        // Long pre count over a short history gives a short window.
        send_idle_pct = 48;
        recv_idle_pct = 18;
        wait_drained();
        set_capture_config(3'($urandom), SAMPLE_W'($urandom), 10'd512, 10'd0);
        capture_run(30, 12, 0);

        start = words_sent;
        while (words_sent - start < SMALL_ITEMS)
        begin
            progress = words_sent - start;
            if (progress < SMALL_ITEMS / 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 48;
            end
            else if (progress < 2 * SMALL_ITEMS / 3)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pre  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 20);
            post = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 20);
            wait_drained();
            set_capture_config(3'($urandom), pick_level(), COUNT_W'(pre), COUNT_W'(post));
            repeat ($urandom_range(1, 3))
                capture_run($urandom_range(0, pre + 6), $urandom_range(3, 12), 8);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS pretrigger_capture_buffer_core");
        else
            $display("FAIL pretrigger_capture_buffer_core");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAIL pretrigger_capture_buffer_core");
        $finish;
    end

endmodule
